// File: rtl/round_robin_ready_queue_defines.svh
// ----------------------------------------------------------------------------
// Round-robin ready queue: assertion macros
// Shared assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_READY_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue: package
// Request, response and entry types, codes and controller signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_ALARM = 2'd1;
   localparam logic [1:0] FUNC_TERM  = 2'd2;

   // Response status codes.
   localparam logic [2:0] STAT_DONE     = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_NOPROC   = 3'd2;
   localparam logic [2:0] STAT_DISABLED = 3'd3;
   localparam logic [2:0] STAT_KEPT     = 3'd4;
   localparam logic [2:0] STAT_NORUN    = 3'd5;

   // Process id range; the counter wraps from the last id back to the first.
   localparam logic [15:0] ID_FIRST = 16'd1;
   localparam logic [15:0] ID_LAST  = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] new_pc;
      logic [31:0] new_sp;
      logic [31:0] new_fp;
      logic [31:0] saved_pc;
      logic [31:0] saved_sp;
      logic [31:0] saved_fp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        load_context;
      logic [31:0] load_pc;
      logic [31:0] load_sp;
      logic [31:0] load_fp;
      logic        running_valid;
      logic [15:0] running_id;
      logic [15:0] assigned_id;
   } rsp_type;

   // One ready-queue entry.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] pc;
      logic [31:0] sp;
      logic [31:0] fp;
   } entry_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: rtl/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue: controller
// Sequences each request through capture and execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrq_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire rrq_pkg::ctrl_status_type dp_status,
   output rrq_pkg::ctrl_cmd_type         dp_cmd
);
   import rrq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands. A request is executed once the output
   // register is free or its contents are being taken.
   always_comb begin
      state_in       = state_ff;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!dp_status.rsp_busy) begin
               dp_cmd.execute = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/rrq_dpath.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue: datapath
// Entry memory, queue pointers, running process and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrq_dpath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrq_pkg::ctrl_cmd_type dp_cmd,
   output rrq_pkg::ctrl_status_type   dp_status,
   input  wire rrq_pkg::req_type      req_payload,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rrq_pkg::rsp_type           rsp_payload
);
   import rrq_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // Entry store and its registered read port at the head.
   entry_type               entry_mem_ff [QUEUE_DEPTH];
   entry_type               head_entry_ff;

   req_type                 req_ff;
   req_type                 req_in;
   logic [PTR_W-1:0]        head_ff;
   logic [PTR_W-1:0]        head_in;
   logic [PTR_W-1:0]        tail_ff;
   logic [PTR_W-1:0]        tail_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;
   logic                    cur_valid_ff;
   logic                    cur_valid_in;
   logic [15:0]             cur_id_ff;
   logic [15:0]             cur_id_in;
   logic [15:0]             id_ctr_ff;
   logic [15:0]             id_ctr_in;
   logic                    enable_ff;
   logic                    enable_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   logic                    q_empty;
   logic                    q_full;
   logic                    push_en;
   logic                    pop_en;
   logic                    load;
   logic [2:0]              status;
   logic [15:0]             assigned;
   logic                    next_valid;
   logic [15:0]             next_id;
   entry_type               wr_data;
   logic [PTR_W-1:0]        head_step;
   logic [PTR_W-1:0]        tail_step;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == COUNT_W'(QUEUE_DEPTH));

   // Circular pointer advance for any depth.
   assign head_step = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_step = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);

   // Decision logic for the captured request.
   always_comb begin
      status     = STAT_DONE;
      load       = 1'b0;
      push_en    = 1'b0;
      pop_en     = 1'b0;
      assigned   = '0;
      next_valid = cur_valid_ff;
      next_id    = cur_id_ff;
      id_ctr_in  = id_ctr_ff;
      wr_data    = '{id: cur_id_ff, pc: req_ff.saved_pc, sp: req_ff.saved_sp,
                     fp: req_ff.saved_fp};
      case (req_ff.func)
         FUNC_ADD: begin
            if (q_full) begin
               status = STAT_FULL;
            end else begin
               push_en  = 1'b1;
               assigned = id_ctr_ff;
               wr_data  = '{id: id_ctr_ff, pc: req_ff.new_pc, sp: req_ff.new_sp,
                            fp: req_ff.new_fp};
               id_ctr_in = (id_ctr_ff == ID_LAST) ? ID_FIRST : id_ctr_ff + 16'd1;
            end
         end
         FUNC_ALARM: begin
            if (q_empty && !cur_valid_ff) begin
               status = STAT_NOPROC;
            end else if (!enable_ff) begin
               status = STAT_DISABLED;
            end else if (q_empty) begin
               status = STAT_KEPT;
            end else begin
               // The running process, if any, goes back to the tail.
               pop_en     = 1'b1;
               push_en    = cur_valid_ff;
               load       = 1'b1;
               next_valid = 1'b1;
               next_id    = head_entry_ff.id;
            end
         end
         FUNC_TERM: begin
            if (!cur_valid_ff) begin
               status = STAT_NORUN;
            end else if (q_empty) begin
               next_valid = 1'b0;
               next_id    = '0;
            end else begin
               pop_en  = 1'b1;
               load    = 1'b1;
               next_id = head_entry_ff.id;
            end
         end
         default: begin
         end
      endcase
   end

   // Next values of the scheduler state.
   always_comb begin
      req_in       = dp_cmd.capture ? req_payload : req_ff;
      enable_in    = csr_write_enable ? csr_write_data : enable_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_valid_in = cur_valid_ff;
      cur_id_in    = cur_id_ff;
      if (dp_cmd.execute) begin
         if (pop_en) begin
            head_in = head_step;
         end
         if (push_en) begin
            tail_in = tail_step;
         end
         if (push_en && !pop_en) begin
            count_in = count_ff + COUNT_W'(1);
         end else if (pop_en && !push_en) begin
            count_in = count_ff - COUNT_W'(1);
         end
         cur_valid_in = next_valid;
         cur_id_in    = next_id;
      end
   end

   // Response assembly and output register handshake.
   always_comb begin
      rsp_in.status        = status;
      rsp_in.load_context  = load;
      rsp_in.load_pc       = load ? head_entry_ff.pc : '0;
      rsp_in.load_sp       = load ? head_entry_ff.sp : '0;
      rsp_in.load_fp       = load ? head_entry_ff.fp : '0;
      rsp_in.running_valid = next_valid;
      rsp_in.running_id    = next_valid ? next_id : '0;
      rsp_in.assigned_id   = assigned;
      if (dp_cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_id_ff    <= '0;
         id_ctr_ff    <= ID_FIRST;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         cur_id_ff    <= cur_id_in;
         id_ctr_ff    <= (dp_cmd.execute) ? id_ctr_in : id_ctr_ff;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (dp_cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // Entry memory: one write at the tail, one registered read at the head.
   always_ff @(posedge clock) begin
      if (dp_cmd.execute && push_en) begin
         entry_mem_ff[tail_ff] <= wr_data;
      end
      head_entry_ff <= entry_mem_ff[head_ff];
   end

   assign dp_status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/round_robin_ready_queue.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue
// Hardware round-robin process scheduler with a circular ready queue.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid / req_stall with a req_payload holding the
// function (add, alarm tick, terminate) and the new and saved contexts. A
// request is taken at a clock edge with req_valid high and req_stall low.
// Each request gives exactly one response on rsp_valid / rsp_stall.
// The block takes one request at a time: a capture step takes the request
// while the entry memory reads the queue head into its output register, and
// an execute step decides, updates the queue and loads the response register.
// While a response waits under rsp_stall the next request is still taken,
// and it is held in its execute cycle until the output register frees.
// csr_write_enable / csr_write_data set the scheduler enable bit.
// Synchronous reset empties the queue, clears the running process, sets the
// id counter to one, clears the enable bit and drops any pending response.
// Queue entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_ready_queue_defines.svh"

module round_robin_ready_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rrq_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rrq_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data
);
   import rrq_pkg::*;

   ctrl_cmd_type    dp_cmd;
   ctrl_status_type dp_status;

   // Sequencing of requests.
   rrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Queue storage and scheduling decisions.
   rrq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   // A taken request moves the block into execution and blocks new requests.
   `RRQ_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall, "request taken but block not busy")
   // Execution always leaves a response in the output register.
   `RRQ_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, dp_cmd.execute, rsp_valid, "execution without response")
   // A stalled response is never overwritten by a new one.
   `RRQ_ASSERT_SAME(a_no_overwrite, clock, reset, dp_cmd.execute, !(rsp_valid && rsp_stall), "stalled response overwritten")
   // A loaded context always leaves a process running.
   `RRQ_ASSERT_SAME(a_load_running, clock, reset, rsp_valid && rsp_payload.load_context, rsp_payload.running_valid, "context loaded with nothing running")

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue: testbench
// Sends add, alarm and terminate requests with random gaps and response
// stalls, predicts every response from a behavioural copy of the scheduler
// and compares the responses field by field. Covers the empty, disabled
// and full cases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rrq_pkg::*;

   localparam int QDEPTH = 16;
   // Function code with no meaning; the block must leave everything alone.
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;

   // Behavioural copy of the scheduler state.
   entry_type   ready_ring [QDEPTH];
   int          ring_head;
   int          ring_tail;
   int          ring_count;
   logic        run_valid;
   logic [15:0] run_id;
   logic [15:0] id_to_give;
   logic        sched_on;

   rsp_type pending_rsp [$];
   int      fail_count = 0;
   bit      idling_on = 1'b1;
   int      stall_left = 0;

   round_robin_ready_queue #(
      .QUEUE_DEPTH(QDEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #1 clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type make_request(input logic [1:0] f);
      req_type r;
      r.func     = f;
      r.new_pc   = rand_word();
      r.new_sp   = rand_word();
      r.new_fp   = rand_word();
      r.saved_pc = rand_word();
      r.saved_sp = rand_word();
      r.saved_fp = rand_word();
      return r;
   endfunction

   function automatic req_type uniform_request(input logic [1:0] f, input logic [31:0] w);
      req_type r;
      r.func     = f;
      r.new_pc   = w;
      r.new_sp   = w;
      r.new_fp   = w;
      r.saved_pc = w;
      r.saved_sp = w;
      r.saved_fp = w;
      return r;
   endfunction

   function automatic void clear_schedule();
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      run_valid  = 1'b0;
      run_id     = '0;
      id_to_give = ID_FIRST;
      sched_on   = 1'b0;
   endfunction

   function automatic void ring_push(input logic [15:0] id, input logic [31:0] pc,
                                     input logic [31:0] sp, input logic [31:0] fp);
      ready_ring[ring_tail].id = id;
      ready_ring[ring_tail].pc = pc;
      ready_ring[ring_tail].sp = sp;
      ready_ring[ring_tail].fp = fp;
      ring_tail  = (ring_tail + 1) % QDEPTH;
      ring_count = ring_count + 1;
   endfunction

   function automatic entry_type ring_pop();
      entry_type e;
      e          = ready_ring[ring_head];
      ring_head  = (ring_head + 1) % QDEPTH;
      ring_count = ring_count - 1;
      return e;
   endfunction

   // Applies one request to the scheduler copy and returns its response.
   function automatic rsp_type schedule_event(input req_type r);
      rsp_type   res;
      entry_type popped;
      res        = '0;
      res.status = STAT_DONE;
      case (r.func)
         FUNC_ADD: begin
            if (ring_count >= QDEPTH) begin
               res.status = STAT_FULL;
            end else begin
               res.assigned_id = id_to_give;
               ring_push(id_to_give, r.new_pc, r.new_sp, r.new_fp);
               id_to_give = (id_to_give == ID_LAST) ? ID_FIRST : id_to_give + 16'd1;
            end
         end
         FUNC_ALARM: begin
            if (ring_count == 0 && !run_valid) begin
               res.status = STAT_NOPROC;
            end else if (!sched_on) begin
               res.status = STAT_DISABLED;
            end else if (ring_count == 0) begin
               res.status = STAT_KEPT;
            end else begin
               // The head leaves first, so the running process always fits.
               popped = ring_pop();
               if (run_valid) begin
                  ring_push(run_id, r.saved_pc, r.saved_sp, r.saved_fp);
               end
               run_valid        = 1'b1;
               run_id           = popped.id;
               res.load_context = 1'b1;
               res.load_pc      = popped.pc;
               res.load_sp      = popped.sp;
               res.load_fp      = popped.fp;
            end
         end
         FUNC_TERM: begin
            if (!run_valid) begin
               res.status = STAT_NORUN;
            end else if (ring_count == 0) begin
               run_valid = 1'b0;
               run_id    = '0;
            end else begin
               popped           = ring_pop();
               run_id           = popped.id;
               res.load_context = 1'b1;
               res.load_pc      = popped.pc;
               res.load_sp      = popped.sp;
               res.load_fp      = popped.fp;
            end
         end
         default: begin
         end
      endcase
      res.running_valid = run_valid;
      res.running_id    = run_valid ? run_id : 16'd0;
      return res;
   endfunction

   // Sends one request, optionally after a gap, and records its predicted response.
   task automatic send_request(input req_type r);
      int gap;
      gap = (idling_on && $urandom_range(0, 1) == 1) ? pick_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = r;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(schedule_event(r));
   endtask

   // Stops sending and waits until every response has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_enable(input logic v);
      drain();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sched_on         = v;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Response stall: random stretches of stall, none while idling is off.
   always @(negedge clock) begin
      if (!idling_on) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  = 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
         stall_left = pick_length() - 1;
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Each accepted response is compared with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response accepted with no request outstanding");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("load_context", want.load_context, rsp_payload.load_context);
            check_field("load_pc", want.load_pc, rsp_payload.load_pc);
            check_field("load_sp", want.load_sp, rsp_payload.load_sp);
            check_field("load_fp", want.load_fp, rsp_payload.load_fp);
            check_field("running_valid", want.running_valid, rsp_payload.running_valid);
            check_field("running_id", want.running_id, rsp_payload.running_id);
            check_field("assigned_id", want.assigned_id, rsp_payload.assigned_id);
         end
      end
   end

   // Empty, disabled, kept, switch and terminate cases plus the spare code.
   task automatic test_directed();
      set_enable(1'b0);
      send_request(uniform_request(FUNC_ALARM, 32'h0000_0000));
      send_request(uniform_request(FUNC_TERM, 32'h0000_0000));
      send_request(uniform_request(FUNC_SPARE, 32'hFFFF_FFFF));
      send_request(uniform_request(FUNC_ADD, 32'h0000_0000));
      send_request(uniform_request(FUNC_ADD, 32'hFFFF_FFFF));
      send_request(make_request(FUNC_ALARM));
      send_request(make_request(FUNC_TERM));
      set_enable(1'b1);
      // First switch has nothing running, the second saves the runner.
      send_request(make_request(FUNC_ALARM));
      send_request(uniform_request(FUNC_ALARM, 32'hFFFF_FFFF));
      send_request(make_request(FUNC_TERM));
      send_request(make_request(FUNC_TERM));
      send_request(make_request(FUNC_ALARM));
      send_request(make_request(FUNC_ADD));
      send_request(make_request(FUNC_ALARM));
      send_request(make_request(FUNC_ALARM));
      send_request(make_request(FUNC_SPARE));
      send_request(make_request(FUNC_TERM));
   endtask

   // Fills the queue, has an add refused and switches while full.
   task automatic test_queue_full();
      while (ring_count < QDEPTH) send_request(make_request(FUNC_ADD));
      send_request(make_request(FUNC_ADD));
      send_request(make_request(FUNC_ALARM));
      send_request(make_request(FUNC_ALARM));
   endtask

   // Random requests, weighted so the queue moves between empty and full.
   task automatic test_random(input int count);
      int         roll;
      int         add_weight;
      logic [1:0] f;
      repeat (count) begin
         if (ring_count >= QDEPTH) add_weight = 15;
         else if (ring_count < 4) add_weight = 50;
         else add_weight = 37;
         roll = $urandom_range(0, 99);
         if (roll < 4) f = FUNC_SPARE;
         else if (roll < 4 + add_weight) f = FUNC_ADD;
         else if (roll < 22 + add_weight) f = FUNC_TERM;
         else f = FUNC_ALARM;
         send_request(make_request(f));
      end
   endtask

   initial begin
      clear_schedule();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_queue_full();
      test_random(500);
      set_enable(1'b0);
      test_random(200);
      set_enable(1'b1);
      idling_on = 1'b0;
      test_random(300);
      idling_on = 1'b1;
      test_random(550);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/rrq_pkg.sv
rtl/rrq_ctrl.sv
rtl/rrq_dpath.sv
rtl/round_robin_ready_queue.sv
tb/tb.sv
